// ===== hw/rtl/chi_pkg.sv =====
// ----------------------------------------------------------------------------
// chi_pkg
// Shared types, constants and slot hash helpers for the cuckoo hash insert
// block.
// ----------------------------------------------------------------------------
package chi_pkg;

	// table geometry (power of two, so both hashes are bit fields of the key)
	localparam int SIZE   = 16;
	localparam int SLOT_W = $clog2(SIZE);
	localparam int KEY_W  = 31;
	localparam int KICK_W = 8;
	localparam int STAT_W = 2;

	localparam logic [KICK_W-1:0] KICKS_RESET = 8'd16;

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DROP = 2'd1;
	localparam logic [STAT_W-1:0] STAT_READ = 2'd2;

	// classified command handed from front to back
	typedef struct packed {
		logic              is_read;
		logic [KEY_W-1:0]  key;
		logic              tsel;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	// first table slot: key mod SIZE
	function automatic logic [SLOT_W-1:0] slot_one(input logic [KEY_W-1:0] k);
		return k[SLOT_W-1:0];
	endfunction

	// second table slot: (key div SIZE) mod SIZE
	function automatic logic [SLOT_W-1:0] slot_two(input logic [KEY_W-1:0] k);
		return k[2*SLOT_W-1:SLOT_W];
	endfunction

endpackage

// ===== hw/rtl/chi_fifo.sv =====
// ----------------------------------------------------------------------------
// chi_fifo
// Small command queue between the front and the back of the hash block.
// ----------------------------------------------------------------------------
module chi_fifo
	import chi_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/chi_front.sv =====
// ----------------------------------------------------------------------------
// chi_front
// Accepts items, classifies them into read or insert commands with their
// first probe slot, and hands them to the command queue.
// ----------------------------------------------------------------------------
module chi_front
	import chi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              action,
	input  logic [KEY_W-1:0]  key,
	input  logic              table_select,
	input  logic [SLOT_W-1:0] slot_index,
	output logic              q_push,
	output cmd_t              q_cmd,
	input  logic              q_full
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_new;
	logic accept;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1;
	assign q_cmd  = cmd_s1;

	// classify: reads keep their slot, inserts start at the first table hash
	always_comb begin
		cmd_new.is_read = (action == ACT_READ);
		cmd_new.key     = key;
		cmd_new.tsel    = (action == ACT_READ) && table_select;
		cmd_new.slot    = (action == ACT_READ) ? slot_index : slot_one(key);
	end

	// stage register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

	// stage holds until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && q_full);
		end
	end

endmodule

// ===== hw/rtl/chi_back.sv =====
// ----------------------------------------------------------------------------
// chi_back
// Carries out commands: owns both hash tables, walks the eviction chain one
// probe at a time, and holds the result in an output register.
// ----------------------------------------------------------------------------
module chi_back
	import chi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [KICK_W-1:0] max_kicks,
	input  cmd_t              cmd_head,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	input  logic              pop,
	output logic              empty,
	output logic [STAT_W-1:0] status,
	output logic              entry_valid,
	output logic [KEY_W-1:0]  entry_key,
	output logic [KICK_W-1:0] moves_used
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	cmd_t              cmd_q;
	logic [KEY_W-1:0]  carried_q;
	logic [KEY_W-1:0]  carried_d;
	logic              tsel_q;
	logic              tsel_d;
	logic [SLOT_W-1:0] addr_q;
	logic [SLOT_W-1:0] addr_d;
	logic [KICK_W-1:0] moves_q;
	logic [KICK_W-1:0] moves_d;
	logic [STAT_W-1:0] res_status_q;
	logic [STAT_W-1:0] res_status_d;
	logic              res_valid_q;
	logic              res_valid_d;
	logic [KEY_W-1:0]  res_key_q;
	logic [KEY_W-1:0]  res_key_d;

	// tables: keys in memories, occupancy in flops
	logic [KEY_W-1:0]  mem1 [SIZE];
	logic [KEY_W-1:0]  mem2 [SIZE];
	logic [SIZE-1:0]   valid1_q;
	logic [SIZE-1:0]   valid2_q;
	logic [KEY_W-1:0]  rdata1_q;
	logic [KEY_W-1:0]  rdata2_q;
	logic [SLOT_W-1:0] rd_addr;
	logic              wr1;
	logic              wr2;
	logic [KEY_W-1:0]  wr_data;
	logic              hit_valid;
	logic [KEY_W-1:0]  hit_key;

	// output register
	logic              out_valid_q;
	logic              out_load;

	assign hit_valid = tsel_q ? valid2_q[addr_q] : valid1_q[addr_q];
	assign hit_key   = tsel_q ? rdata2_q : rdata1_q;

	// sequencer
	always_comb begin
		state_d      = state_q;
		carried_d    = carried_q;
		tsel_d       = tsel_q;
		addr_d       = addr_q;
		moves_d      = moves_q;
		res_status_d = res_status_q;
		res_valid_d  = res_valid_q;
		res_key_d    = res_key_q;
		rd_addr      = addr_q;
		wr1          = 1'b0;
		wr2          = 1'b0;
		wr_data      = carried_q;
		cmd_pop      = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = cmd_head.slot;
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					addr_d  = cmd_head.slot;
					tsel_d  = cmd_head.tsel;
					moves_d = '0;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (cmd_q.is_read) begin
					res_status_d = STAT_READ;
					res_valid_d  = hit_valid;
					res_key_d    = hit_valid ? hit_key : '0;
					state_d      = ST_DONE;
				end else begin
					wr1     = 1'b1;
					wr_data = cmd_q.key;
					if (!hit_valid) begin
						res_status_d = STAT_OK;
						res_valid_d  = 1'b0;
						res_key_d    = '0;
						state_d      = ST_DONE;
					end else begin
						carried_d = hit_key;
						tsel_d    = 1'b1;
						state_d   = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (moves_q >= max_kicks) begin
					res_status_d = STAT_DROP;
					res_valid_d  = 1'b1;
					res_key_d    = carried_q;
					state_d      = ST_DONE;
				end else begin
					rd_addr = tsel_q ? slot_two(carried_q) : slot_one(carried_q);
					addr_d  = rd_addr;
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				wr1 = !tsel_q;
				wr2 = tsel_q;
				if (!hit_valid) begin
					res_status_d = STAT_OK;
					res_valid_d  = 1'b0;
					res_key_d    = '0;
					state_d      = ST_DONE;
				end else begin
					carried_d = hit_key;
					tsel_d    = !tsel_q;
					moves_d   = moves_q + 1'b1;
					state_d   = ST_WALK;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// key memories with registered read
	always_ff @(posedge clk) begin
		if (wr1) begin
			mem1[addr_q] <= wr_data;
		end
		if (wr2) begin
			mem2[addr_q] <= wr_data;
		end
		rdata1_q <= mem1[rd_addr];
		rdata2_q <= mem2[rd_addr];
	end

	// occupancy bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid1_q <= '0;
			valid2_q <= '0;
		end else begin
			if (wr1) begin
				valid1_q[addr_q] <= 1'b1;
			end
			if (wr2) begin
				valid2_q[addr_q] <= 1'b1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk payload and result fields
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_head;
		end
		carried_q    <= carried_d;
		tsel_q       <= tsel_d;
		addr_q       <= addr_d;
		moves_q      <= moves_d;
		res_status_q <= res_status_d;
		res_valid_q  <= res_valid_d;
		res_key_q    <= res_key_d;
		if (out_load) begin
			status      <= res_status_q;
			entry_valid <= res_valid_q;
			entry_key   <= res_key_q;
			moves_used  <= (res_status_q == STAT_READ) ? '0 : moves_q;
		end
	end

	assign empty = !out_valid_q;

	// a new command is only taken while the sequencer is idle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == ST_IDLE)
		else $error("command popped while busy");

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !pop) |=> state_q == ST_DONE)
		else $error("result register overrun");

	// a dropped key is always reported as present
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status == STAT_DROP) |-> entry_valid)
		else $error("drop without key");

	// read replies carry no move count
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status == STAT_READ) |-> moves_used == '0)
		else $error("read reply with moves");

	// loading the result frees the sequencer on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result load did not complete");

endmodule

// ===== hw/rtl/cuckoo_hash_insert.sv =====
// ----------------------------------------------------------------------------
// cuckoo_hash_insert
// Two-table cuckoo hash store with insert and slot read commands.
// ----------------------------------------------------------------------------
// Items enter through a registered front stage and a small command queue, so
// new items are taken while the back end works on an earlier one and while a
// finished result waits to be popped. The back end takes one command at a
// time. A read is answered from one lookup of the selected slot. An insert
// that finds its first table slot free is written there at once; each
// eviction probe is one registered read of a table, then the swap write,
// and an insert whose walk reaches the kick limit drops the key it still
// carries. The walk is paced by the single read port of each table memory.
// Both tables read as empty after reset with no clearing pass; max_kicks
// resets to 16 and should be written only while the block is idle.
module cuckoo_hash_insert
	import chi_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              action,
	input  logic [KEY_W-1:0]  key,
	input  logic              table_select,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic              pop,
	output logic              empty,
	output logic [STAT_W-1:0] status,
	output logic              entry_valid,
	output logic [KEY_W-1:0]  entry_key,
	output logic [KICK_W-1:0] moves_used,
	input  logic              cfg_we,
	input  logic [KICK_W-1:0] cfg_wdata
);

	logic [KICK_W-1:0] max_kicks_q;
	logic              q_push;
	cmd_t              q_cmd;
	logic              q_full;
	cmd_t              q_head;
	logic              q_empty;
	logic              q_pop;

	// kick limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_kicks_q <= KICKS_RESET;
		end else if (cfg_we) begin
			max_kicks_q <= cfg_wdata;
		end
	end

	// intake and classification
	chi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.key          (key),
		.table_select (table_select),
		.slot_index   (slot_index),
		.q_push       (q_push),
		.q_cmd        (q_cmd),
		.q_full       (q_full)
	);

	// command queue
	chi_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// table engine and result register
	chi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_kicks   (max_kicks_q),
		.cmd_head    (q_head),
		.cmd_empty   (q_empty),
		.cmd_pop     (q_pop),
		.pop         (pop),
		.empty       (empty),
		.status      (status),
		.entry_valid (entry_valid),
		.entry_key   (entry_key),
		.moves_used  (moves_used)
	);

endmodule

// ===== tb/sv/cuckoo_hash_insert_test.sv =====
// ----------------------------------------------------------------------------
// cuckoo_hash_insert_test
// Self-checking bench for the two-table cuckoo hash store. A queue-fed driver
// pushes insert and read items with random gaps. Each item is predicted by a
// local copy of both tables and the kick limit when the block accepts it. A
// monitor pops results with random stalls and compares every field with the
// oldest prediction. The kick limit is rewritten between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module cuckoo_hash_insert_test;
	import chi_pkg::*;

	localparam int STALL_LIMIT = 4000;

	// one item as it is queued for the driver
	typedef struct packed {
		logic              action;
		logic [KEY_W-1:0]  key;
		logic              table_select;
		logic [SLOT_W-1:0] slot_index;
		logic              drain;
	} req_t;

	// one predicted result
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              entry_valid;
		logic [KEY_W-1:0]  entry_key;
		logic [KICK_W-1:0] moves_used;
	} reply_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              action = 1'b0;
	logic [KEY_W-1:0]  key = '0;
	logic              table_select = 1'b0;
	logic [SLOT_W-1:0] slot_index = '0;
	logic              pop = 1'b0;
	logic              empty;
	logic [STAT_W-1:0] status;
	logic              entry_valid;
	logic [KEY_W-1:0]  entry_key;
	logic [KICK_W-1:0] moves_used;
	logic              cfg_we = 1'b0;
	logic [KICK_W-1:0] cfg_wdata = '0;

	// predicted table contents and kick limit
	bit                first_used [SIZE];
	bit [KEY_W-1:0]    first_keys [SIZE];
	bit                second_used [SIZE];
	bit [KEY_W-1:0]    second_keys [SIZE];
	logic [KICK_W-1:0] kick_limit = KICKS_RESET;

	req_t   item_q[$];
	reply_t reply_q[$];
	req_t   cur_item;
	bit     staged;
	int     send_wait;
	int     pop_wait;
	bit     no_idle;
	int     errors;
	int     idle_cycles;

	cuckoo_hash_insert uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.key(key),
		.table_select(table_select),
		.slot_index(slot_index),
		.pop(pop),
		.empty(empty),
		.status(status),
		.entry_valid(entry_valid),
		.entry_key(entry_key),
		.moves_used(moves_used),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// apply one item to the predicted tables and return its result
	function automatic reply_t cuckoo_apply(req_t r);
		reply_t            rep;
		int                p;
		int                s;
		logic [KEY_W-1:0]  carried;
		logic [KEY_W-1:0]  swap;
		int                moves;
		bit                to_second;
		bit                placed;
		rep = '0;
		if (r.action == ACT_READ) begin
			rep.status = STAT_READ;
			if (r.table_select) begin
				rep.entry_valid = second_used[r.slot_index];
				rep.entry_key = second_used[r.slot_index] ? second_keys[r.slot_index] : '0;
			end else begin
				rep.entry_valid = first_used[r.slot_index];
				rep.entry_key = first_used[r.slot_index] ? first_keys[r.slot_index] : '0;
			end
			return rep;
		end
		rep.status = STAT_OK;
		p = r.key % SIZE;
		// free home slot
		if (!first_used[p]) begin
			first_used[p] = 1'b1;
			first_keys[p] = r.key;
			return rep;
		end
		carried = first_keys[p];
		first_keys[p] = r.key;
		moves = 0;
		to_second = 1'b1;
		placed = 1'b0;
		// relocation walk, alternating tables
		while (!placed && moves < kick_limit) begin
			if (to_second) begin
				s = (carried / SIZE) % SIZE;
				if (!second_used[s]) begin
					second_used[s] = 1'b1;
					second_keys[s] = carried;
					placed = 1'b1;
				end else begin
					swap = second_keys[s];
					second_keys[s] = carried;
					carried = swap;
				end
			end else begin
				s = carried % SIZE;
				if (!first_used[s]) begin
					first_used[s] = 1'b1;
					first_keys[s] = carried;
					placed = 1'b1;
				end else begin
					swap = first_keys[s];
					first_keys[s] = carried;
					carried = swap;
				end
			end
			if (!placed) begin
				to_second = !to_second;
				moves++;
			end
		end
		rep.moves_used = KICK_W'(moves);
		// kick limit spent: carried key is dropped
		if (!placed) begin
			rep.status = STAT_DROP;
			rep.entry_valid = 1'b1;
			rep.entry_key = carried;
		end
		return rep;
	endfunction

	// random item, keys often clustered so that slots collide
	function automatic req_t random_req(int insert_pct);
		req_t r;
		r.action = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_READ;
		r.key = KEY_W'($urandom);
		if ($urandom_range(0, 1)) begin
			r.key[7:4] = 4'($urandom_range(0, 3));
			r.key[3:0] = 4'($urandom_range(0, 3));
		end
		r.table_select = 1'($urandom_range(0, 1));
		r.slot_index = SLOT_W'($urandom_range(0, SIZE - 1));
		r.drain = 1'b0;
		return r;
	endfunction

	task automatic add_req(logic act, logic [KEY_W-1:0] k, logic tsel, logic [SLOT_W-1:0] idx);
		req_t r;
		r.action = act;
		r.key = k;
		r.table_select = tsel;
		r.slot_index = idx;
		r.drain = 1'b0;
		item_q.push_back(r);
	endtask

	// wait until every item is accepted and every result popped
	task automatic settle();
		while (item_q.size() != 0 || staged || push || reply_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_kicks(logic [KICK_W-1:0] kicks);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= kicks;
		kick_limit = kicks;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one random phase; the middle item waits for all results first
	task automatic run_phase(logic [KICK_W-1:0] kicks, int count, int insert_pct, bit eager);
		req_t r;
		write_kicks(kicks);
		no_idle = eager;
		for (int i = 0; i < count; i++) begin
			r = random_req(insert_pct);
			r.drain = (i == count / 2);
			item_q.push_back(r);
		end
	endtask

	// driver: present queued items, predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		logic send;
		if (!arst_n) begin
			push <= 1'b0;
			staged = 1'b0;
			send_wait = 0;
		end else begin
			send = 1'b0;
			if (push && !full)
				reply_q.push_back(cuckoo_apply(cur_item));
			if (!push || !full) begin
				if (!staged && item_q.size() != 0) begin
					cur_item = item_q.pop_front();
					send_wait = no_idle ? 0 : $urandom_range(0, 3);
					staged = 1'b1;
				end
				if (staged) begin
					if (send_wait != 0)
						send_wait--;
					else if (!cur_item.drain || reply_q.size() == 0) begin
						send = 1'b1;
						staged = 1'b0;
					end
				end
				push <= send;
				if (send) begin
					action <= cur_item.action;
					key <= cur_item.key;
					table_select <= cur_item.table_select;
					slot_index <= cur_item.slot_index;
				end
			end
		end
	end

	// monitor: pop results with random stalls, compare with oldest prediction
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			pop_wait = 0;
		end else begin
			if (pop && !empty) begin
				if (reply_q.size() == 0) begin
					$error("unexpected item: status %0d, key %0h", status, entry_key);
					errors++;
				end else begin
					want = reply_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (entry_valid !== want.entry_valid) begin
						$error("entry_valid: expected %0d, got %0d",
							want.entry_valid, entry_valid);
						errors++;
					end
					if (entry_key !== want.entry_key) begin
						$error("entry_key: expected %0h, got %0h", want.entry_key, entry_key);
						errors++;
					end
					if (moves_used !== want.moves_used) begin
						$error("moves_used: expected %0d, got %0d",
							want.moves_used, moves_used);
						errors++;
					end
				end
				pop_wait = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (pop_wait != 0) begin
				pop_wait--;
				pop <= 1'b0;
			end else
				pop <= 1'b1;
		end
	end

	// watchdog: too long without any accepted item, popped result or config write
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("cuckoo_hash_insert: mismatch");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset kick limit: free slots, evictions, a cycling walk
		add_req(ACT_INSERT, 31'd0, 1'b0, '0);
		add_req(ACT_INSERT, 31'h7FFF_FFFF, 1'b1, 4'hF);
		add_req(ACT_READ, 31'h7FFF_FFFF, 1'b0, 4'd7);
		add_req(ACT_INSERT, 31'd16, 1'b0, '0);
		add_req(ACT_INSERT, 31'd256, 1'b0, '0);
		add_req(ACT_INSERT, 31'd512, 1'b0, '0);
		add_req(ACT_INSERT, 31'h11, 1'b0, '0);
		add_req(ACT_INSERT, 31'h21, 1'b0, '0);
		add_req(ACT_INSERT, 31'h11, 1'b0, '0);
		add_req(ACT_INSERT, 31'h7FFF_FFF0, 1'b0, '0);
		add_req(ACT_READ, '0, 1'b0, 4'd0);
		add_req(ACT_READ, '0, 1'b0, 4'd1);
		add_req(ACT_READ, '0, 1'b0, 4'hF);
		add_req(ACT_READ, '0, 1'b1, 4'd0);
		add_req(ACT_READ, '0, 1'b1, 4'd1);
		add_req(ACT_READ, 31'h7FFF_FFFF, 1'b1, 4'hF);

		// kick limit of zero: a displaced key is dropped at once
		write_kicks(8'd0);
		add_req(ACT_INSERT, 31'h3F, 1'b0, '0);
		add_req(ACT_INSERT, 31'h45, 1'b0, '0);
		add_req(ACT_INSERT, 31'h45, 1'b0, '0);
		add_req(ACT_READ, '0, 1'b0, 4'hF);
		add_req(ACT_READ, '0, 1'b0, 4'd5);
		add_req(ACT_READ, '0, 1'b1, 4'd4);

		// random phases over several kick limits
		run_phase(8'd1, 60, 30, 1'b0);
		run_phase(8'd255, 24, 50, 1'b0);
		run_phase(8'd7, 120, 50, 1'b0);
		run_phase(8'd3, 60, 50, 1'b1);
		run_phase(KICK_W'($urandom_range(2, 40)), 120, 60, 1'b0);
		run_phase(8'd2, 66, 40, 1'b0);

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0 && reply_q.size() == 0)
			$display("cuckoo_hash_insert: match");
		else
			$display("cuckoo_hash_insert: mismatch");
		$finish;
	end

endmodule
